// File: design/mean_speed_shortfall_score_unit_defines.svh
// Assertion macros for the mean speed shortfall score unit.
`ifndef MEAN_SPEED_SHORTFALL_SCORE_UNIT_DEFINES_SVH
`define MEAN_SPEED_SHORTFALL_SCORE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MSSU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSSU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mssu_pkg.sv
// Shared constants and types of the mean speed shortfall score unit.
package mssu_pkg;

  localparam int unsigned MaxPoses  = 256;
  localparam int unsigned PoseCntW  = $clog2(MaxPoses + 1);
  localparam int unsigned CoordW    = 32;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned SqW       = 2 * DiffW;
  localparam int unsigned RootW     = DiffW;
  localparam int unsigned PathW     = 48;
  localparam int unsigned HalfW     = PathW / 2;
  localparam int unsigned NsW       = 30;
  localparam int unsigned ProdW     = HalfW + NsW;
  localparam int unsigned NumW      = PathW + NsW;
  localparam int unsigned TimeW     = 40;
  localparam int unsigned DivW      = TimeW - 1;
  localparam int unsigned RemW      = DivW + 1;
  localparam int unsigned ScoreW    = 24;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned StepCntW  = 6;
  localparam int unsigned SqrtSteps = RootW;
  localparam int unsigned DivSteps  = ScoreW;

  localparam logic [NsW-1:0]    NsPerS    = 30'd1000000000;
  localparam logic [ScoreW-1:0] TargetRst = 24'd78643;

  typedef enum logic [CfgIdxW-1:0] {
    RegTargetSpeed = 2'd0,
    RegStartX      = 2'd1,
    RegStartY      = 2'd2
  } mssu_reg_e;

  typedef enum logic {
    ModeSqrt = 1'b0,
    ModeDiv  = 1'b1
  } mssu_mode_e;

  typedef struct packed {
    logic             start;
    mssu_mode_e       mode;
    logic [SqW-1:0]   src;
    logic [DivW-1:0]  rem;
    logic [DivW-1:0]  divisor;
  } mssu_iter_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RootW-1:0] result;
  } mssu_iter_stat_t;

endpackage

// File: design/mssu_pose_if.sv
// Pose input channel: valid/ready handshake with one trajectory pose.
interface mssu_pose_if;
  logic        valid;
  logic        ready;
  logic [31:0] pose_x;
  logic [31:0] pose_y;
  logic        last_pose;
  logic        empty_trajectory;
  logic [39:0] end_time_ns;

  modport source (
    output valid, pose_x, pose_y, last_pose, empty_trajectory, end_time_ns,
    input  ready
  );
  modport sink (
    input  valid, pose_x, pose_y, last_pose, empty_trajectory, end_time_ns,
    output ready
  );
endinterface

// File: design/mssu_score_if.sv
// Score output channel: valid/ready handshake with one trajectory score.
interface mssu_score_if;
  logic        valid;
  logic        ready;
  logic [23:0] score;
  logic        used_default;

  modport source (
    output valid, score, used_default,
    input  ready
  );
  modport sink (
    input  valid, score, used_default,
    output ready
  );
endinterface

// File: design/mssu_mul.sv
// Shared unsigned multiplier with registered product.
module mssu_mul (
  input  logic                         clk_i,
  input  logic [mssu_pkg::DiffW-1:0]   a_i,
  input  logic [mssu_pkg::DiffW-1:0]   b_i,
  output logic [mssu_pkg::SqW-1:0]     p_o
);

  logic [mssu_pkg::SqW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: design/mssu_iter.sv
// Shared shift-subtract unit: bitwise square root and restoring division.
module mssu_iter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mssu_pkg::mssu_iter_cmd_t      cmd_i,
  output mssu_pkg::mssu_iter_stat_t     stat_o
);

  mssu_pkg::mssu_mode_e               mode_q;
  logic [mssu_pkg::SqW-1:0]           src_q;
  logic [mssu_pkg::RemW-1:0]          rem_q;
  logic [mssu_pkg::RootW-1:0]         acc_q;
  logic [mssu_pkg::DivW-1:0]          div_q;
  logic [mssu_pkg::StepCntW-1:0]      cnt_q;
  logic                               busy_q;
  logic                               done_q;

  logic [mssu_pkg::RemW-1:0]          shifted;
  logic [mssu_pkg::RemW-1:0]          subtr;
  logic [mssu_pkg::RemW:0]            diff;
  logic                               ge;

  always_comb begin
    if (mode_q == mssu_pkg::ModeSqrt) begin
      shifted = {rem_q[mssu_pkg::RemW-3:0], src_q[mssu_pkg::SqW-1 -: 2]};
      subtr   = {{(mssu_pkg::RemW - mssu_pkg::RootW - 2){1'b0}}, acc_q, 2'b01};
    end else begin
      shifted = {rem_q[mssu_pkg::RemW-2:0], src_q[mssu_pkg::SqW-1]};
      subtr   = {{(mssu_pkg::RemW - mssu_pkg::DivW){1'b0}}, div_q};
    end
    diff = {1'b0, shifted} - {1'b0, subtr};
    ge   = ~diff[mssu_pkg::RemW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (cmd_i.mode == mssu_pkg::ModeSqrt) ?
                  mssu_pkg::StepCntW'(mssu_pkg::SqrtSteps) :
                  mssu_pkg::StepCntW'(mssu_pkg::DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mssu_pkg::StepCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= cmd_i.mode;
      src_q  <= cmd_i.src;
      rem_q  <= {{(mssu_pkg::RemW - mssu_pkg::DivW){1'b0}}, cmd_i.rem};
      acc_q  <= '0;
      div_q  <= cmd_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[mssu_pkg::RemW-1:0] : shifted;
      acc_q <= {acc_q[mssu_pkg::RootW-2:0], ge};
      src_q <= (mode_q == mssu_pkg::ModeSqrt) ? (src_q << 2) : (src_q << 1);
    end
  end

  assign stat_o.busy   = busy_q;
  assign stat_o.done   = done_q;
  assign stat_o.result = acc_q;

endmodule

// File: design/mean_speed_shortfall_score_unit.sv
// Top level of the mean speed shortfall score unit.
// Takes one pose per transaction, accumulates the step lengths of a trajectory
// and, on the last pose, returns the target speed minus the mean speed (floored
// at zero) in Q8.16 m/s. The input is ready only while the sequencer is idle.
// A pose that is not last passes through StSqX and StSqY on the shared
// multiplier for the squares, StSum to sum, StSqrt for the 33-step root
// iteration of the shift-subtract unit and StAcc to accumulate. A last pose
// adds StMul0 and StMul1 on the multiplier for distance times 1e9, the StNum
// compare, the 24-step quotient iteration of the same unit in StDiv and StEmit
// to post the result. A quotient of 2^24 or more skips the iteration and posts
// zero. An empty trajectory goes straight to StEmit and posts the target. A last
// pose with a nonpositive duration still takes the step, skips the product and
// the quotient, and posts the target. The result sits in an output register, so
// the next pose is taken while a score waits to be read.
`include "mean_speed_shortfall_score_unit_defines.svh"

module mean_speed_shortfall_score_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mssu_pose_if.sink                         pose_i,
  mssu_score_if.source                      score_o,
  input  logic                              cfg_we_i,
  input  logic [mssu_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mssu_pkg::CfgW-1:0]         cfg_data_i
);

  typedef enum logic [10:0] {
    StIdle = 11'b00000000001,
    StSqX  = 11'b00000000010,
    StSqY  = 11'b00000000100,
    StSum  = 11'b00000001000,
    StSqrt = 11'b00000010000,
    StAcc  = 11'b00000100000,
    StMul0 = 11'b00001000000,
    StMul1 = 11'b00010000000,
    StNum  = 11'b00100000000,
    StDiv  = 11'b01000000000,
    StEmit = 11'b10000000000
  } mssu_state_e;

  mssu_state_e                         state_q, state_d;

  logic [mssu_pkg::ScoreW-1:0]         target_q;
  logic [mssu_pkg::CoordW-1:0]         start_x_q;
  logic [mssu_pkg::CoordW-1:0]         start_y_q;

  logic                                run_active_q;
  logic [mssu_pkg::PoseCntW-1:0]       pose_cnt_q;
  logic [mssu_pkg::PathW-1:0]          path_q;
  logic [mssu_pkg::CoordW-1:0]         prev_x_q;
  logic [mssu_pkg::CoordW-1:0]         prev_y_q;

  logic [mssu_pkg::DiffW-1:0]          ax_q;
  logic [mssu_pkg::DiffW-1:0]          ay_q;
  logic                                last_q;
  logic [mssu_pkg::TimeW-1:0]          ns_q;
  logic [mssu_pkg::SqW-1:0]            sx_q;
  logic [mssu_pkg::ProdW-1:0]          p0_q;

  logic [mssu_pkg::ScoreW-1:0]         res_score_q;
  logic                                res_dflt_q;
  logic                                out_valid_q;
  logic [mssu_pkg::ScoreW-1:0]         out_score_q;
  logic                                out_dflt_q;

  logic                                pose_fire;
  logic                                emit_fire;
  logic [mssu_pkg::CoordW-1:0]         base_x;
  logic [mssu_pkg::CoordW-1:0]         base_y;
  logic [mssu_pkg::DiffW-1:0]          dx;
  logic [mssu_pkg::DiffW-1:0]          dy;
  logic [mssu_pkg::DiffW-1:0]          ax;
  logic [mssu_pkg::DiffW-1:0]          ay;
  logic [mssu_pkg::DiffW-1:0]          mul_a;
  logic [mssu_pkg::DiffW-1:0]          mul_b;
  logic [mssu_pkg::SqW-1:0]            mul_p;
  logic [mssu_pkg::SqW-1:0]            sq_sum;
  logic [mssu_pkg::PathW:0]            step_sum;
  logic [mssu_pkg::NumW-1:0]           num;
  logic                                big;
  logic                                ns_nonpos;
  logic [mssu_pkg::ScoreW-1:0]         quot;
  logic [mssu_pkg::ScoreW-1:0]         shortfall;

  mssu_pkg::mssu_iter_cmd_t            iter_cmd;
  mssu_pkg::mssu_iter_stat_t           iter_stat;

  mssu_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mssu_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (iter_cmd),
    .stat_o (iter_stat)
  );

  assign pose_i.ready = (state_q == StIdle);
  assign pose_fire    = pose_i.valid && (state_q == StIdle);
  assign emit_fire    = (state_q == StEmit) && (!out_valid_q || score_o.ready);

  assign score_o.valid        = out_valid_q;
  assign score_o.score        = out_score_q;
  assign score_o.used_default = out_dflt_q;

  always_comb begin
    base_x = run_active_q ? prev_x_q : start_x_q;
    base_y = run_active_q ? prev_y_q : start_y_q;
    dx = {pose_i.pose_x[mssu_pkg::CoordW-1], pose_i.pose_x} -
         {base_x[mssu_pkg::CoordW-1], base_x};
    dy = {pose_i.pose_y[mssu_pkg::CoordW-1], pose_i.pose_y} -
         {base_y[mssu_pkg::CoordW-1], base_y};
    ax = dx[mssu_pkg::DiffW-1] ? (~dx + 1'b1) : dx;
    ay = dy[mssu_pkg::DiffW-1] ? (~dy + 1'b1) : dy;

    case (state_q)
      StSqY: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      StMul0: begin
        mul_a = {{(mssu_pkg::DiffW - mssu_pkg::HalfW){1'b0}},
                 path_q[mssu_pkg::HalfW-1:0]};
        mul_b = {{(mssu_pkg::DiffW - mssu_pkg::NsW){1'b0}}, mssu_pkg::NsPerS};
      end
      StMul1: begin
        mul_a = {{(mssu_pkg::DiffW - mssu_pkg::HalfW){1'b0}},
                 path_q[mssu_pkg::PathW-1:mssu_pkg::HalfW]};
        mul_b = {{(mssu_pkg::DiffW - mssu_pkg::NsW){1'b0}}, mssu_pkg::NsPerS};
      end
      default: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
    endcase

    sq_sum   = sx_q + mul_p;
    step_sum = {1'b0, path_q} +
               {{(mssu_pkg::PathW + 1 - mssu_pkg::RootW){1'b0}}, iter_stat.result};
    num = {{mssu_pkg::HalfW{1'b0}}, p0_q} +
          {mul_p[mssu_pkg::ProdW-1:0], {mssu_pkg::HalfW{1'b0}}};
    big = num[mssu_pkg::NumW-1:mssu_pkg::ScoreW] >=
          {{(mssu_pkg::NumW - mssu_pkg::ScoreW - mssu_pkg::DivW){1'b0}},
           ns_q[mssu_pkg::DivW-1:0]};
    ns_nonpos = ns_q[mssu_pkg::TimeW-1] || (ns_q == '0);
    quot      = iter_stat.result[mssu_pkg::ScoreW-1:0];
    shortfall = (target_q > quot) ? (target_q - quot) : '0;

    iter_cmd.start   = (state_q == StSum) || ((state_q == StNum) && !big);
    iter_cmd.mode    = (state_q == StNum) ? mssu_pkg::ModeDiv : mssu_pkg::ModeSqrt;
    iter_cmd.src     = (state_q == StNum) ?
                       {num[mssu_pkg::ScoreW-1:0],
                        {(mssu_pkg::SqW - mssu_pkg::ScoreW){1'b0}}} :
                       sq_sum;
    iter_cmd.rem     = (state_q == StNum) ?
                       num[mssu_pkg::ScoreW + mssu_pkg::DivW - 1:mssu_pkg::ScoreW] :
                       '0;
    iter_cmd.divisor = ns_q[mssu_pkg::DivW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (pose_fire) begin
        state_d = pose_i.empty_trajectory ? StEmit : StSqX;
      end
      StSqX:  state_d = StSqY;
      StSqY:  state_d = StSum;
      StSum:  state_d = StSqrt;
      StSqrt: if (iter_stat.done) begin
        state_d = StAcc;
      end
      StAcc: begin
        if (!last_q) begin
          state_d = StIdle;
        end else if (ns_nonpos) begin
          state_d = StEmit;
        end else begin
          state_d = StMul0;
        end
      end
      StMul0: state_d = StMul1;
      StMul1: state_d = StNum;
      StNum:  state_d = big ? StEmit : StDiv;
      StDiv:  if (iter_stat.done) begin
        state_d = StEmit;
      end
      StEmit: if (emit_fire) begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      target_q     <= mssu_pkg::TargetRst;
      start_x_q    <= '0;
      start_y_q    <= '0;
      run_active_q <= 1'b0;
      pose_cnt_q   <= '0;
      path_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (mssu_pkg::mssu_reg_e'(cfg_idx_i))
          mssu_pkg::RegTargetSpeed: target_q  <= cfg_data_i[mssu_pkg::ScoreW-1:0];
          mssu_pkg::RegStartX:      start_x_q <= cfg_data_i;
          mssu_pkg::RegStartY:      start_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (pose_fire && !pose_i.empty_trajectory) begin
        run_active_q <= 1'b1;
      end
      if ((state_q == StAcc) &&
          (pose_cnt_q < mssu_pkg::PoseCntW'(mssu_pkg::MaxPoses))) begin
        path_q     <= step_sum[mssu_pkg::PathW] ? '1 : step_sum[mssu_pkg::PathW-1:0];
        pose_cnt_q <= pose_cnt_q + 1'b1;
      end
      if (emit_fire) begin
        path_q       <= '0;
        pose_cnt_q   <= '0;
        run_active_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (score_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pose_fire) begin
      ax_q     <= ax;
      ay_q     <= ay;
      last_q   <= pose_i.last_pose;
      ns_q     <= pose_i.end_time_ns;
      if (!pose_i.empty_trajectory) begin
        prev_x_q <= pose_i.pose_x;
        prev_y_q <= pose_i.pose_y;
      end else begin
        res_score_q <= target_q;
        res_dflt_q  <= 1'b1;
      end
    end
    if (state_q == StSqY) begin
      sx_q <= mul_p;
    end
    if (state_q == StMul1) begin
      p0_q <= mul_p[mssu_pkg::ProdW-1:0];
    end
    if ((state_q == StAcc) && last_q && ns_nonpos) begin
      res_score_q <= target_q;
      res_dflt_q  <= 1'b1;
    end
    if ((state_q == StNum) && big) begin
      res_score_q <= '0;
      res_dflt_q  <= 1'b0;
    end
    if ((state_q == StDiv) && iter_stat.done) begin
      res_score_q <= shortfall;
      res_dflt_q  <= 1'b0;
    end
    if (emit_fire) begin
      out_score_q <= res_score_q;
      out_dflt_q  <= res_dflt_q;
    end
  end

  `MSSU_ASSERT_IMP(a_iter_owned, clk_i, rst_ni, iter_stat.busy || iter_stat.done,
    state_q == StSqrt || state_q == StDiv, "shift-subtract unit active outside its states")
  `MSSU_ASSERT_NXT(a_accept_next, clk_i, rst_ni, pose_fire,
    state_q == StSqX || state_q == StEmit, "accepted pose did not start processing")
  `MSSU_ASSERT_NXT(a_run_cleared, clk_i, rst_ni, emit_fire,
    !run_active_q && path_q == '0 && pose_cnt_q == '0, "run state not cleared after score")

endmodule

// File: tb/mean_speed_shortfall_score_unit_checker.sv
// Scoreboard for the mean speed shortfall score unit: predicts and checks every score.
`timescale 1ns / 100ps

module mean_speed_shortfall_score_unit_checker
  import mssu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  mssu_pose_if               pose_i,
  mssu_score_if              score_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  localparam logic [29:0] NANOS_PER_SEC = 30'd1000000000;
  localparam logic [40:0] SPEED_CAP     = 41'h100_0000_0000;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              used_default;
  } shortfall_t;

  shortfall_t          shortfall_q[$];
  logic [ScoreW-1:0]   speed_goal;
  logic [CoordW-1:0]   origin_x;
  logic [CoordW-1:0]   origin_y;
  logic [PathW-1:0]    path_len;
  logic [CoordW-1:0]   prev_x;
  logic [CoordW-1:0]   prev_y;
  logic                run_open;
  int unsigned         poses_taken;
  int unsigned         mismatches = 0;
  int unsigned         waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  function automatic logic [RootW-1:0] floor_sqrt(input logic [65:0] radicand);
    logic [39:0] root;
    logic [39:0] rem;
    logic [39:0] trial;
    root = '0;
    rem  = '0;
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | {38'd0, radicand[2*i +: 2]};
      trial = (root << 2) | 40'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 40'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[RootW-1:0];
  endfunction

  function automatic logic [RootW-1:0] step_length(input logic [CoordW-1:0] from_x,
                                                   input logic [CoordW-1:0] from_y,
                                                   input logic [CoordW-1:0] to_x,
                                                   input logic [CoordW-1:0] to_y);
    logic [DiffW:0]   dx;
    logic [DiffW:0]   dy;
    logic [DiffW-1:0] mx;
    logic [DiffW-1:0] my;
    dx = {{2{to_x[CoordW-1]}}, to_x} - {{2{from_x[CoordW-1]}}, from_x};
    dy = {{2{to_y[CoordW-1]}}, to_y} - {{2{from_y[CoordW-1]}}, from_y};
    mx = dx[DiffW] ? (~dx[DiffW-1:0] + 1'b1) : dx[DiffW-1:0];
    my = dy[DiffW] ? (~dy[DiffW-1:0] + 1'b1) : dy[DiffW-1:0];
    return floor_sqrt({33'd0, mx} * {33'd0, mx} + {33'd0, my} * {33'd0, my});
  endfunction

  // distance * 1e9 / duration, clamped to 2^40
  function automatic logic [40:0] avg_speed(input logic [PathW-1:0] span,
                                            input logic [TimeW-1:0] dur);
    logic [127:0] quo;
    quo = ({80'd0, span} * {98'd0, NANOS_PER_SEC}) / {88'd0, dur};
    return (quo >= {87'd0, SPEED_CAP}) ? SPEED_CAP : quo[40:0];
  endfunction

  function void close_run();
    path_len    = '0;
    prev_x      = origin_x;
    prev_y      = origin_y;
    run_open    = 1'b0;
    poses_taken = 0;
  endfunction

  function void post_shortfall(input logic [ScoreW-1:0] score, input logic dflt);
    shortfall_t item;
    item.score        = score;
    item.used_default = dflt;
    shortfall_q.push_back(item);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    shortfall_t              want;
    logic [RootW-1:0]        step;
    logic [PathW:0]          sum;
    logic [40:0]             speed;
    logic signed [TimeW-1:0] dur;
    if (!rst_ni) begin
      speed_goal = TargetRst;
      origin_x   = '0;
      origin_y   = '0;
      close_run();
      shortfall_q.delete();
      waiting = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegTargetSpeed: speed_goal = cfg_data_i[ScoreW-1:0];
          RegStartX:      origin_x = cfg_data_i;
          RegStartY:      origin_y = cfg_data_i;
          default: ;
        endcase
      end

      if (pose_i.valid && pose_i.ready) begin
        if (pose_i.empty_trajectory) begin
          close_run();
          post_shortfall(speed_goal, 1'b1);
        end else begin
          if (!run_open) begin
            prev_x   = origin_x;
            prev_y   = origin_y;
            run_open = 1'b1;
          end
          step = step_length(prev_x, prev_y, pose_i.pose_x, pose_i.pose_y);
          // poses beyond the per-run cap still move the previous pose
          if (poses_taken < MaxPoses) begin
            sum = {1'b0, path_len} + {16'd0, step};
            path_len = sum[PathW] ? '1 : sum[PathW-1:0];
            poses_taken++;
          end
          prev_x = pose_i.pose_x;
          prev_y = pose_i.pose_y;
          if (pose_i.last_pose) begin
            dur = pose_i.end_time_ns;
            if (dur <= 0) begin
              post_shortfall(speed_goal, 1'b1);
            end else begin
              speed = avg_speed(path_len, dur);
              post_shortfall((speed_goal > speed) ? speed_goal - speed[ScoreW-1:0] : '0,
                             1'b0);
            end
            close_run();
          end
        end
      end

      if (score_i.valid && score_i.ready) begin
        if (shortfall_q.size() == 0) begin
          mismatches++;
          $display("%0t: score transaction with none expected: score %0d used_default %0b",
                   $time, score_i.score, score_i.used_default);
        end else begin
          want = shortfall_q.pop_front();
          if (score_i.score !== want.score) begin
            mismatches++;
            $display("%0t: score mismatch: expected %0d, actual %0d",
                     $time, want.score, score_i.score);
          end
          if (score_i.used_default !== want.used_default) begin
            mismatches++;
            $display("%0t: used_default mismatch: expected %0b, actual %0b",
                     $time, want.used_default, score_i.used_default);
          end
        end
      end
      waiting = shortfall_q.size();
    end
  end

endmodule

// File: tb/mean_speed_shortfall_score_unit_tb.sv
// Testbench top for the mean speed shortfall score unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module mean_speed_shortfall_score_unit_tb;
  import mssu_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PHASE_ITEMS   = 300;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned TAIL_CYCLES   = 100;
  localparam int unsigned STALL_AT      = 25;
  localparam int unsigned STALL_CYCLES  = 600;
  localparam int unsigned CALM_FROM     = 120;
  localparam int unsigned CALM_TO       = 200;

  typedef enum {
    WalkWide,
    WalkNear,
    WalkEdges
  } walk_style_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;
  int unsigned        fail_count;
  int unsigned        pending;
  logic               pose_calm;
  int unsigned        items_sent;
  logic [CoordW-1:0]  origin_x;
  logic [CoordW-1:0]  origin_y;
  logic [CoordW-1:0]  walk_x;
  logic [CoordW-1:0]  walk_y;

  mssu_pose_if  pose_if ();
  mssu_score_if score_if ();

  mean_speed_shortfall_score_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pose_i     (pose_if),
    .score_o    (score_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  mean_speed_shortfall_score_unit_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pose_i       (pose_if),
    .score_i      (score_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [TimeW-1:0] pick_duration();
    logic [TimeW-1:0] ns;
    int unsigned      pick;
    pick = $urandom_range(99);
    ns   = {8'($urandom), 32'($urandom)};
    if (pick < 4) begin
      ns = '0;
    end else if (pick < 8) begin
      ns[TimeW-1] = 1'b1;
    end else if (pick < 10) begin
      ns = pick[0] ? 40'h80_0000_0000 : '1;
    end else if (pick >= 20) begin
      ns = ns >> (TimeW - $urandom_range(1, 39));
      if (ns == '0) ns = 40'd1;
    end
    return ns;
  endfunction

  function automatic logic [CoordW-1:0] pick_coord(input logic [CoordW-1:0] near,
                                                   input walk_style_e style);
    case (style)
      WalkWide: return $urandom;
      WalkNear: return near + 32'($urandom_range(0, 524288)) - 32'd262144;
      default: begin
        case ($urandom_range(4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '0;
          3:       return '1;
          default: return near + 32'($urandom_range(0, 4096)) - 32'd2048;
        endcase
      end
    endcase
  endfunction

  task automatic send_pose(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                           input logic last, input logic empty, input logic [TimeW-1:0] ns);
    if (!pose_calm && $urandom_range(99) < 15) begin
      pose_if.valid <= 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8))
        @(posedge clk_i);
    end
    pose_if.valid            <= 1'b1;
    pose_if.pose_x           <= x;
    pose_if.pose_y           <= y;
    pose_if.last_pose        <= last;
    pose_if.empty_trajectory <= empty;
    pose_if.end_time_ns      <= ns;
    do @(posedge clk_i); while (!pose_if.ready);
    items_sent++;
  endtask

  task automatic send_trajectory(input int unsigned poses, input logic plain);
    walk_style_e       style;
    int unsigned       kind;
    int unsigned       pick;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    kind  = plain ? 99 : $urandom_range(99);
    pick  = $urandom_range(9);
    style = (pick < 2) ? WalkWide : (pick == 9) ? WalkEdges : WalkNear;
    walk_x = origin_x;
    walk_y = origin_y;
    if (kind < 6) begin
      send_pose($urandom, $urandom, 1'($urandom), 1'b1, pick_duration());
    end else begin
      for (int i = 1; i <= poses; i++) begin
        x = pick_coord(walk_x, style);
        y = pick_coord(walk_y, style);
        walk_x = x;
        walk_y = y;
        send_pose(x, y, kind >= 12 && i == poses, 1'b0, pick_duration());
      end
      // abandoned trajectory: poses followed by an empty marker
      if (kind < 12) send_pose($urandom, $urandom, 1'($urandom), 1'b1, pick_duration());
    end
  endtask

  task automatic drain_scores();
    pose_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [ScoreW-1:0] target, input logic [CoordW-1:0] sx,
                           input logic [CoordW-1:0] sy, input logic calm,
                           input logic long_run);
    int unsigned goal;
    drain_scores();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegTargetSpeed;
    cfg_data <= {8'd0, target};
    @(posedge clk_i);
    cfg_idx  <= RegStartX;
    cfg_data <= sx;
    @(posedge clk_i);
    cfg_idx  <= RegStartY;
    cfg_data <= sy;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    origin_x  = sx;
    origin_y  = sy;
    pose_calm = calm;
    goal = items_sent + PHASE_ITEMS;
    if (long_run) send_trajectory(300, 1'b1);
    while (items_sent < goal)
      send_trajectory(($urandom_range(99) < 85) ? $urandom_range(1, 5) : $urandom_range(6, 40),
                      1'b0);
  endtask

  initial begin : stimulus
    pose_if.valid            = 1'b0;
    pose_if.pose_x           = '0;
    pose_if.pose_y           = '0;
    pose_if.last_pose        = 1'b0;
    pose_if.empty_trajectory = 1'b0;
    pose_if.end_time_ns      = '0;
    cfg_we     = 1'b0;
    cfg_idx    = RegTargetSpeed;
    cfg_data   = '0;
    pose_calm  = 1'b0;
    items_sent = 0;
    origin_x   = '0;
    origin_y   = '0;
    walk_x     = '0;
    walk_y     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset configuration
    send_pose(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, '1);
    send_pose('0, '0, 1'b1, 1'b1, '0);
    send_pose('0, '0, 1'b1, 1'b0, 40'd1);
    send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    send_pose(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 40'd1);
    send_pose(32'h8000_0000, '0, 1'b1, 1'b0, '0);
    send_pose(32'd65536, '0, 1'b1, 1'b0, 40'h80_0000_0000);
    send_pose(32'd65536, '0, 1'b1, 1'b0, 40'h7F_FFFF_FFFF);
    send_pose(32'd65536, '0, 1'b0, 1'b0, '0);
    send_pose(32'd131072, '0, 1'b1, 1'b0, 40'd1_666_666_667);
    send_pose(32'd100, 32'd100, 1'b0, 1'b0, '0);
    send_pose('1, '1, 1'b0, 1'b1, 40'd5);
    send_pose(32'd3, 32'd4, 1'b1, 1'b0, 40'd1_000_000_000);
    send_pose('1, '1, 1'b1, 1'b0, 40'd1);

    run_phase(24'hFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    run_phase('0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    run_phase(24'($urandom), $urandom, $urandom, 1'b0, 1'b0);
    run_phase(TargetRst, '0, '0, 1'b0, 1'b1);
    run_phase(24'($urandom_range(1, 300000)), $urandom, $urandom, 1'b0, 1'b0);
    run_phase(24'($urandom_range(60000, 100000)), 32'($urandom_range(0, 1 << 20)),
              32'($urandom_range(0, 1 << 20)), 1'b0, 1'b0);

    drain_scores();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("mean_speed_shortfall_score_unit_tb passed");
    end else begin
      $display("mean_speed_shortfall_score_unit_tb failed");
    end
    $finish;
  end

  initial begin : score_drain
    int unsigned drained;
    int unsigned held;
    logic        stalled;
    drained = 0;
    stalled = 1'b0;
    score_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (score_if.valid && score_if.ready) drained++;
      if (drained == STALL_AT && !stalled) begin
        // long hold-off so the block backs up and stalls its input
        stalled = 1'b1;
        score_if.ready <= 1'b0;
        for (held = 0; held < STALL_CYCLES; held++) @(posedge clk_i);
        score_if.ready <= 1'b1;
      end else if (drained >= CALM_FROM && drained < CALM_TO) begin
        score_if.ready <= 1'b1;
      end else begin
        score_if.ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("mean_speed_shortfall_score_unit_tb failed");
    $finish;
  end

endmodule
